// ===== sv/ring_buffer_index_manager_with_peek_top_defines.svh =====
// Assertion macros shared by the ring buffer index manager modules
`ifndef RING_BUFFER_INDEX_MANAGER_WITH_PEEK_TOP_DEFINES_SVH
`define RING_BUFFER_INDEX_MANAGER_WITH_PEEK_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RBIM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RBIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RBIM_ASSERT(lbl, prop, msg)
`define RBIM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/rbim_pkg.sv =====
// Shared types, constants and helpers of the ring buffer index manager
`timescale 1ns / 1ps
package rbim_pkg;

	localparam int unsigned MAX_SLOTS_DEF = 1024;

	localparam int unsigned MODE_W  = 3;
	localparam int unsigned REQ_W   = 16;
	localparam int unsigned CAP_W   = 11;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned OCNT_W  = 11;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 48;

	localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(1024);

	// register indexes on the configuration port
	localparam logic REG_CAPACITY   = 1'b0;
	localparam logic REG_START_FULL = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_ONE = 3'd0,
		OP_POP_ONE  = 3'd1,
		OP_PUSH_RUN = 3'd2,
		OP_POP_RUN  = 3'd3,
		OP_PEEK_ONE = 3'd4,
		OP_REWIND   = 3'd5,
		OP_COMMIT   = 3'd6,
		OP_PEEK_RUN = 3'd7
	} op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic exec;
		logic init;
	} cmd_t;

	// result item, ok in the lowest bit
	typedef struct packed {
		logic [OCNT_W-1:0] peekable_count;
		logic [OCNT_W-1:0] fill_count;
		logic [OCNT_W-1:0] granted_count;
		logic [IDX_W-1:0]  slot_index;
		logic              ok;
	} res_t;

	// clamp a programmed capacity into 1..max_slots
	function automatic int unsigned eff_cap(logic [CAP_W-1:0] c, int unsigned max_slots);
		int unsigned v;
		v = (c == '0) ? 1 : int'(c);
		if (v > max_slots) begin
			v = max_slots;
		end
		return v;
	endfunction

endpackage

// ===== sv/rbim_cfg.sv =====
// Configuration registers and reinitialisation request of the index manager
`timescale 1ns / 1ps
module rbim_cfg #(
	parameter int unsigned MAX_SLOTS = rbim_pkg::MAX_SLOTS_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rbim_pkg::ADDR_W-1:0]  paddr,
	input  logic [rbim_pkg::DATA_W-1:0]  pwdata,
	output logic [rbim_pkg::DATA_W-1:0]  prdata,
	output logic [CNT_W-1:0]             cap,
	output logic [CNT_W-1:0]             init_fill,
	output logic                         init
);

	logic [rbim_pkg::CAP_W-1:0] capacity_q;
	logic                       start_full_q;
	logic                       reg_sel;
	logic [rbim_pkg::CAP_W-1:0] cap_new;
	logic                       sf_new;

	assign reg_sel = paddr[2];
	assign init    = psel & penable & pwrite;

	// take the written value over the held one for the new fill
	always_comb begin
		cap_new = capacity_q;
		sf_new  = start_full_q;
		unique case (reg_sel)
			rbim_pkg::REG_CAPACITY:   cap_new = pwdata[rbim_pkg::CAP_W-1:0];
			rbim_pkg::REG_START_FULL: sf_new  = pwdata[0];
			default: ;
		endcase
	end

	assign cap       = CNT_W'(rbim_pkg::eff_cap(capacity_q, MAX_SLOTS));
	assign init_fill = sf_new ? CNT_W'(rbim_pkg::eff_cap(cap_new, MAX_SLOTS)) : '0;

	// hold the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= rbim_pkg::CAPACITY_RST;
			start_full_q <= 1'b0;
		end else if (init) begin
			capacity_q   <= cap_new;
			start_full_q <= sf_new;
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			rbim_pkg::REG_CAPACITY:   prdata = rbim_pkg::DATA_W'(capacity_q);
			rbim_pkg::REG_START_FULL: prdata = rbim_pkg::DATA_W'(start_full_q);
			default: ;
		endcase
	end

endmodule

// ===== sv/rbim_ctrl.sv =====
// Controller: accept items and hold the output register's occupancy
`timescale 1ns / 1ps
`include "ring_buffer_index_manager_with_peek_top_defines.svh"
module rbim_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  logic           cfg_init,
	output rbim_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	// take a new item whenever the output register frees up this cycle
	assign s_tready = (state_q == ST_EMPTY) || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_HOLD);

	assign cmd.exec = accept;
	assign cmd.init = cfg_init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			unique case (state_q)
				ST_EMPTY: begin
					if (accept) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!accept && m_tready) begin
						state_q <= ST_EMPTY;
					end
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

	`RBIM_ASSERT_NEXT(a_accept_gives_result, accept, m_tvalid, "accepted item gave no result")
	`RBIM_ASSERT(a_ready_only_on_stall, !s_tready || !(m_tvalid && !m_tready),
		"input ready while result stalls")
	`RBIM_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !accept, !m_tvalid,
		"result shown twice")

endmodule

// ===== sv/rbim_dp.sv =====
// Datapath: positions, counts and the result register of the index manager
`timescale 1ns / 1ps
`include "ring_buffer_index_manager_with_peek_top_defines.svh"
module rbim_dp #(
	parameter int unsigned MAX_SLOTS = rbim_pkg::MAX_SLOTS_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1),
	localparam int unsigned POS_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbim_pkg::cmd_t              cmd,
	input  logic [rbim_pkg::MODE_W-1:0] mode,
	input  logic [rbim_pkg::REQ_W-1:0]  request_count,
	input  logic [CNT_W-1:0]            cap,
	input  logic [CNT_W-1:0]            init_fill,
	output rbim_pkg::res_t              res
);

	rbim_pkg::op_t op;

	logic [POS_W-1:0] wp_q, rp_q, pp_q;
	logic [CNT_W-1:0] fill_q, peeked_q;

	logic [POS_W-1:0] pos, wp_d, rp_d, pp_d, npos;
	logic [CNT_W-1:0] fill_d, peeked_d;
	logic [CNT_W-1:0] limit, room, run_n, n, pos_ext, sum;
	logic [rbim_pkg::REQ_W-1:0] req_room;
	logic             is_run, blocked;
	rbim_pkg::res_t   res_d;
	rbim_pkg::res_t   res_q;

	assign op = rbim_pkg::op_t'(mode);

	// select the position and headroom the operation works against
	always_comb begin
		pos    = pp_q;
		limit  = '0;
		is_run = 1'b0;
		case (op) inside
			rbim_pkg::OP_PUSH_ONE, rbim_pkg::OP_PUSH_RUN: begin
				pos   = wp_q;
				limit = cap - fill_q;
			end
			rbim_pkg::OP_POP_ONE, rbim_pkg::OP_POP_RUN: begin
				pos   = rp_q;
				limit = fill_q;
			end
			rbim_pkg::OP_PEEK_ONE, rbim_pkg::OP_PEEK_RUN: begin
				pos   = pp_q;
				limit = fill_q - peeked_q;
			end
			default: ;
		endcase
		case (op) inside
			rbim_pkg::OP_PUSH_RUN, rbim_pkg::OP_POP_RUN, rbim_pkg::OP_PEEK_RUN: is_run = 1'b1;
			default: is_run = 1'b0;
		endcase
	end

	// grant up to the wrap point and the headroom, then advance with wrap
	always_comb begin
		pos_ext  = CNT_W'(pos);
		room     = cap - pos_ext;
		req_room = (rbim_pkg::REQ_W'(room) < request_count) ?
			rbim_pkg::REQ_W'(room) : request_count;
		run_n    = (CNT_W'(req_room) < limit) ? CNT_W'(req_room) : limit;
		n        = is_run ? run_n : CNT_W'(1);
		blocked  = (limit == '0);
		sum      = pos_ext + n;
		npos     = (sum >= cap) ? '0 : POS_W'(sum);
	end

	// next state and result
	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		pp_d     = pp_q;
		fill_d   = fill_q;
		peeked_d = peeked_q;
		res_d.ok            = 1'b0;
		res_d.slot_index    = '0;
		res_d.granted_count = '0;
		case (op) inside
			rbim_pkg::OP_PUSH_ONE, rbim_pkg::OP_PUSH_RUN: begin
				if (!blocked) begin
					res_d.ok            = 1'b1;
					res_d.slot_index    = rbim_pkg::IDX_W'(pos);
					res_d.granted_count = rbim_pkg::OCNT_W'(n);
					wp_d                = npos;
					fill_d              = fill_q + n;
				end
			end
			rbim_pkg::OP_POP_ONE, rbim_pkg::OP_POP_RUN: begin
				if (!blocked) begin
					res_d.ok            = 1'b1;
					res_d.slot_index    = rbim_pkg::IDX_W'(pos);
					res_d.granted_count = rbim_pkg::OCNT_W'(n);
					rp_d                = npos;
					pp_d                = npos;
					fill_d              = fill_q - n;
					peeked_d            = '0;
				end
			end
			rbim_pkg::OP_PEEK_ONE, rbim_pkg::OP_PEEK_RUN: begin
				if (!blocked) begin
					res_d.ok            = 1'b1;
					res_d.slot_index    = rbim_pkg::IDX_W'(pos);
					res_d.granted_count = rbim_pkg::OCNT_W'(n);
					pp_d                = npos;
					peeked_d            = peeked_q + n;
				end
			end
			rbim_pkg::OP_REWIND: begin
				res_d.ok = 1'b1;
				pp_d     = rp_q;
				peeked_d = '0;
			end
			default: begin
				// commit what was peeked
				res_d.ok            = 1'b1;
				res_d.granted_count = rbim_pkg::OCNT_W'(peeked_q);
				rp_d                = pp_q;
				fill_d              = fill_q - peeked_q;
				peeked_d            = '0;
			end
		endcase
		res_d.fill_count     = rbim_pkg::OCNT_W'(fill_d);
		res_d.peekable_count = rbim_pkg::OCNT_W'(fill_d - peeked_d);
	end

	// hold the state; reinitialise on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			pp_q     <= '0;
			fill_q   <= '0;
			peeked_q <= '0;
		end else if (cmd.init) begin
			wp_q     <= '0;
			rp_q     <= '0;
			pp_q     <= '0;
			fill_q   <= init_fill;
			peeked_q <= '0;
		end else if (cmd.exec) begin
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			pp_q     <= pp_d;
			fill_q   <= fill_d;
			peeked_q <= peeked_d;
		end
	end

	// load the result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

	`RBIM_ASSERT(a_fill_in_cap, fill_q <= cap, "fill exceeds capacity")
	`RBIM_ASSERT(a_peeked_in_fill, peeked_q <= fill_q, "peeked exceeds fill")
	`RBIM_ASSERT(a_wp_in_cap, CNT_W'(wp_q) < cap, "write position beyond capacity")

endmodule

// ===== sv/ring_buffer_index_manager_with_peek_top.sv =====
// Top level of the ring buffer index manager with peek
`timescale 1ns / 1ps
// Hands out slot indices of a circular buffer; no data passes through it.
// Input channel s_*: one item asks for push, pop, peek, rewind or commit,
// single or as a run. Output channel m_*: one result item per input item,
// giving ok, the first slot, the granted count and both occupancy counts.
// Run requests are cut at the wrap point and at the available headroom.
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; the state update
// and the result are worked out combinationally from the held positions and counts.
// A stalled result is held in the output register; a new item is still
// taken in the cycle the held result is taken, otherwise input waits.
// Reset: positions and counts cleared, capacity 1024, start empty.
// An APB write to either register reinitialises the positions, filling
// the buffer when start_full is set; write only while no item is open.
module ring_buffer_index_manager_with_peek_top #(
	parameter int unsigned MAX_SLOTS = rbim_pkg::MAX_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] mode, [18:3] request_count
	input  logic [rbim_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] ok, [10:1] slot_index, [21:11] granted_count,
	// [32:22] fill_count, [43:33] peekable_count
	output logic [rbim_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rbim_pkg::ADDR_W-1:0]    paddr,
	input  logic [rbim_pkg::DATA_W-1:0]    pwdata,
	output logic [rbim_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

	logic [CNT_W-1:0] cap, init_fill;
	logic             cfg_init;
	rbim_pkg::cmd_t   cmd;
	rbim_pkg::res_t   res;

	assign pready = 1'b1;

	rbim_cfg #(.MAX_SLOTS(MAX_SLOTS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.cap       (cap),
		.init_fill (init_fill),
		.init      (cfg_init)
	);

	rbim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_init (cfg_init),
		.cmd      (cmd)
	);

	rbim_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (s_tdata[rbim_pkg::MODE_W-1:0]),
		.request_count (s_tdata[rbim_pkg::MODE_W +: rbim_pkg::REQ_W]),
		.cap           (cap),
		.init_fill     (init_fill),
		.res           (res)
	);

	// pad the result to whole bytes
	assign m_tdata = rbim_pkg::M_TDATA_W'(res);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the ring buffer index manager with peek
`timescale 1ns / 1ps
module tb_top;
	import rbim_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// [2:0] mode, [18:3] request_count
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	// [0] ok, [10:1] slot_index, [21:11] granted_count,
	// [32:22] fill_count, [43:33] peekable_count
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// slot bookkeeping of the predictor
	logic [CAP_W-1:0]  cfg_capacity;
	logic              cfg_start_full;
	logic [IDX_W-1:0]  write_slot;
	logic [IDX_W-1:0]  read_slot;
	logic [IDX_W-1:0]  peek_slot;
	logic [OCNT_W-1:0] held;
	logic [OCNT_W-1:0] peeked;

	res_t        pending_grants[$];
	int unsigned mismatch_count = 0;
	int unsigned send_gap_pct   = 0;
	int unsigned take_gap_pct   = 0;
	int unsigned hold_left      = 0;
	int unsigned quiet_cycles   = 0;

	ring_buffer_index_manager_with_peek_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// capacity as the block uses it: zero acts as one, clamp at the slot limit
	function automatic int unsigned slots_in_use();
		if (cfg_capacity == '0) begin
			return 1;
		end
		if (cfg_capacity > MAX_SLOTS_DEF) begin
			return MAX_SLOTS_DEF;
		end
		return cfg_capacity;
	endfunction

	function automatic int unsigned lowest(int unsigned a, int unsigned b);
		return (a < b) ? a : b;
	endfunction

	// step a position on, falling back to slot 0 at the wrap point
	function automatic logic [IDX_W-1:0] wrap_slot(logic [IDX_W-1:0] pos, int unsigned n,
			int unsigned cap);
		int unsigned p;
		p = pos + n;
		return (p >= cap) ? '0 : IDX_W'(p);
	endfunction

	function automatic void clear_slot_model();
		write_slot = '0;
		read_slot  = '0;
		peek_slot  = '0;
		peeked     = '0;
		held       = cfg_start_full ? OCNT_W'(slots_in_use()) : '0;
	endfunction

	// apply one operation to the bookkeeping and return the result it gives
	function automatic res_t apply_slot_op(op_t op, logic [REQ_W-1:0] req);
		int unsigned cap;
		int unsigned n;
		res_t r;
		cap = slots_in_use();
		r = '0;
		case (op)
			OP_PUSH_ONE, OP_PUSH_RUN: begin
				if (held < cap) begin
					n = (op == OP_PUSH_ONE) ? 1 :
						lowest(lowest(req, cap - write_slot), cap - held);
					r.ok = 1'b1;
					r.slot_index = write_slot;
					r.granted_count = OCNT_W'(n);
					write_slot = wrap_slot(write_slot, n, cap);
					held = held + OCNT_W'(n);
				end
			end
			OP_POP_ONE, OP_POP_RUN: begin
				if (held != '0) begin
					n = (op == OP_POP_ONE) ? 1 : lowest(lowest(req, cap - read_slot), held);
					r.ok = 1'b1;
					r.slot_index = read_slot;
					r.granted_count = OCNT_W'(n);
					read_slot = wrap_slot(read_slot, n, cap);
					held = held - OCNT_W'(n);
					peek_slot = read_slot;
					peeked = '0;
				end
			end
			OP_PEEK_ONE, OP_PEEK_RUN: begin
				if (held != peeked) begin
					n = (op == OP_PEEK_ONE) ? 1 :
						lowest(lowest(req, cap - peek_slot), held - peeked);
					r.ok = 1'b1;
					r.slot_index = peek_slot;
					r.granted_count = OCNT_W'(n);
					peek_slot = wrap_slot(peek_slot, n, cap);
					peeked = peeked + OCNT_W'(n);
				end
			end
			OP_REWIND: begin
				r.ok = 1'b1;
				peek_slot = read_slot;
				peeked = '0;
			end
			default: begin
				// commit: everything peeked leaves the buffer
				r.ok = 1'b1;
				r.granted_count = peeked;
				read_slot = peek_slot;
				held = held - peeked;
				peeked = '0;
			end
		endcase
		r.fill_count = held;
		r.peekable_count = held - peeked;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatch_count++;
		$display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
	endtask

	// offer one item after a random gap; predict its result once taken
	task automatic send_item(op_t op, logic [REQ_W-1:0] req);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({req, op});
		do @(posedge clk); while (!s_tready);
		pending_grants.push_back(apply_slot_op(op, req));
		@(negedge clk);
	endtask

	// stop offering and wait until every expected result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// two-phase register write; the block reinitialises on the access edge
	task automatic write_register(logic index, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'({index, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (index == REG_CAPACITY) begin
			cfg_capacity = value[CAP_W-1:0];
		end else begin
			cfg_start_full = value[0];
		end
		clear_slot_model();
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [REQ_W-1:0] pick_request();
		case ($urandom_range(3))
			0: begin
				return REQ_W'($urandom_range(0, 3));
			end
			1: begin
				return REQ_W'($urandom_range(0, slots_in_use() + 2));
			end
			2: begin
				return REQ_W'($urandom);
			end
			default: begin
				return REQ_W'($urandom_range(0, 40));
			end
		endcase
	endfunction

	// every operation on the reset setting, failures on empty and full included
	task automatic test_directed_ops();
		send_item(OP_POP_ONE, '0);
		send_item(OP_POP_RUN, 16'd5);
		send_item(OP_PEEK_ONE, '0);
		send_item(OP_PEEK_RUN, 16'd3);
		send_item(OP_REWIND, '0);
		send_item(OP_COMMIT, '0);
		send_item(OP_PUSH_ONE, '0);
		send_item(OP_PUSH_RUN, '0);
		send_item(OP_PUSH_RUN, 16'hFFFF);
		send_item(OP_PUSH_ONE, '0);
		send_item(OP_PUSH_RUN, 16'd1);
		send_item(OP_PEEK_ONE, '0);
		send_item(OP_PEEK_RUN, '0);
		send_item(OP_PEEK_RUN, 16'd10);
		send_item(OP_REWIND, '0);
		send_item(OP_PEEK_RUN, 16'd4);
		send_item(OP_COMMIT, '0);
		send_item(OP_POP_RUN, '0);
		send_item(OP_POP_ONE, '0);
		send_item(OP_PEEK_RUN, 16'hFFFF);
		send_item(OP_PEEK_ONE, '0);
		send_item(OP_POP_RUN, 16'hFFFF);
		send_item(OP_PUSH_RUN, 16'h8000);
	endtask

	// capacity of zero, above the limit and a tiny ring with wrapping runs
	task automatic test_capacity_extremes();
		settle();
		write_register(REG_CAPACITY, '0);
		write_register(REG_START_FULL, 32'd1);
		send_item(OP_PUSH_ONE, '0);
		send_item(OP_PEEK_RUN, 16'hFFFF);
		send_item(OP_COMMIT, '0);
		send_item(OP_POP_ONE, '0);
		send_item(OP_PUSH_RUN, 16'd5);
		settle();
		write_register(REG_CAPACITY, 32'h7FF);
		send_item(OP_PUSH_RUN, 16'd1);
		send_item(OP_POP_RUN, 16'hFFFF);
		send_item(OP_PUSH_ONE, '0);
		settle();
		write_register(REG_START_FULL, '0);
		write_register(REG_CAPACITY, 32'd3);
		send_item(OP_PUSH_RUN, 16'd2);
		send_item(OP_PUSH_RUN, 16'd5);
		send_item(OP_POP_ONE, '0);
		send_item(OP_PUSH_RUN, 16'd5);
		send_item(OP_PEEK_RUN, 16'd5);
		send_item(OP_PEEK_RUN, 16'd5);
		send_item(OP_COMMIT, '0);
		send_item(OP_POP_RUN, '0);
	endtask

	// blocks of random operations, each on a freshly written setting
	task automatic test_random_traffic(int unsigned blocks, int unsigned send_pct,
			int unsigned take_pct);
		logic [CAP_W-1:0] cap;
		send_gap_pct = send_pct;
		take_gap_pct = take_pct;
		repeat (blocks) begin
			settle();
			case ($urandom_range(7))
				0, 1, 2: begin
					cap = CAP_W'($urandom_range(1, 8));
				end
				3: begin
					cap = CAP_W'($urandom_range(9, 64));
				end
				4: begin
					cap = CAP_W'(MAX_SLOTS_DEF);
				end
				5: begin
					cap = CAP_W'($urandom_range(0, 2047));
				end
				default: begin
					cap = ($urandom_range(1) != 0) ? 11'h7FF : 11'h000;
				end
			endcase
			write_register(REG_CAPACITY, DATA_W'(cap));
			write_register(REG_START_FULL, DATA_W'($urandom_range(1)));
			repeat (30) send_item(op_t'($urandom_range(7)), pick_request());
		end
	endtask

	// hold the result side off long enough for the input to stall
	task automatic test_backpressure();
		settle();
		write_register(REG_CAPACITY, 32'd16);
		write_register(REG_START_FULL, '0);
		send_gap_pct = 0;
		take_gap_pct = 0;
		hold_left = 300;
		repeat (40) send_item(op_t'($urandom_range(7)), pick_request());
		settle();
	endtask

	// drive the result side ready, with random gaps or a long hold
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	// check each result item against the oldest expectation
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result, slot_index", got.slot_index, 0);
			end else begin
				want = pending_grants.pop_front();
				if (got.ok !== want.ok) begin
					report_mismatch("ok", got.ok, want.ok);
				end
				if (got.slot_index !== want.slot_index) begin
					report_mismatch("slot_index", got.slot_index, want.slot_index);
				end
				if (got.granted_count !== want.granted_count) begin
					report_mismatch("granted_count", got.granted_count, want.granted_count);
				end
				if (got.fill_count !== want.fill_count) begin
					report_mismatch("fill_count", got.fill_count, want.fill_count);
				end
				if (got.peekable_count !== want.peekable_count) begin
					report_mismatch("peekable_count", got.peekable_count, want.peekable_count);
				end
			end
		end
	end

	// end the run when nothing has been accepted for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		send_gap_pct = 18;
		take_gap_pct = 47;
		cfg_capacity   = CAPACITY_RST;
		cfg_start_full = 1'b0;
		clear_slot_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_capacity_extremes();
		test_random_traffic(6, 18, 47);
		test_random_traffic(6, 47, 18);
		test_random_traffic(6, 0, 0);
		test_backpressure();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
